@@ src/slxfr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slxfr_pkg: shared types and constants of the frame receiver
// Item layouts, status codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package slxfr_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 1;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD  = 1'b1;

    // Register reset values
    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hAA;
    localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RST  = 8'hFF;

    // Event codes of the input item
    localparam logic MODE_BYTE    = 1'b0;
    localparam logic MODE_TIMEOUT = 1'b1;

    typedef enum logic [2:0] {
        KIND_BYTE    = 3'd0,
        KIND_OK      = 3'd1,
        KIND_BADSUM  = 3'd2,
        KIND_TOOLONG = 3'd3,
        KIND_TIMEOUT = 3'd4
    } kind_t;

    typedef struct packed {
        logic              mode;
        logic [BYTE_W-1:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] frame_type;
        logic [BYTE_W-1:0] frame_len;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] byte_index;
        logic              last;
    } res_item_t;

    // Result of one step, handed from the frame tracker to the output stage
    typedef struct packed {
        logic      valid;
        res_item_t item;
    } step_t;

endpackage
`default_nettype wire

@@ src/slxfr_fsm.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slxfr_fsm: frame tracker
// Holds the frame state and the registers, decodes one item per cycle while accept is high.
// ----------------------------------------------------------------------------
module slxfr_fsm (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            accept,
    input  wire slxfr_pkg::in_item_t             item,
    input  wire logic                            cfg_we,
    input  wire logic [slxfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [slxfr_pkg::BYTE_W-1:0]    cfg_data,
    output slxfr_pkg::step_t                     step
);

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_TYPE    = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CHECK   = 3'd4
    } phase_t;

    phase_t                       phase_reg,        phase_next;
    logic [slxfr_pkg::BYTE_W-1:0] start_marker_reg;
    logic [slxfr_pkg::BYTE_W-1:0] max_payload_reg;
    logic [slxfr_pkg::BYTE_W-1:0] held_type_reg,    held_type_next;
    logic [slxfr_pkg::BYTE_W-1:0] held_length_reg,  held_length_next;
    logic [slxfr_pkg::BYTE_W-1:0] bytes_seen_reg,   bytes_seen_next;
    logic [slxfr_pkg::BYTE_W-1:0] running_xor_reg,  running_xor_next;
    logic [slxfr_pkg::BYTE_W-1:0] seen_inc;
    logic [slxfr_pkg::BYTE_W-1:0] b;

    assign b        = item.rx_byte;
    assign seen_inc = bytes_seen_reg + 8'd1;

    always_comb
    begin
        phase_next       = phase_reg;
        held_type_next   = held_type_reg;
        held_length_next = held_length_reg;
        bytes_seen_next  = bytes_seen_reg;
        running_xor_next = running_xor_reg;

        step.valid           = 1'b0;
        step.item.kind       = slxfr_pkg::KIND_BYTE;
        step.item.frame_type = held_type_reg;
        step.item.frame_len  = held_length_reg;
        step.item.data       = '0;
        step.item.byte_index = '0;
        step.item.last       = 1'b0;

        if (item.mode == slxfr_pkg::MODE_TIMEOUT)
        begin
            // abort a frame in progress; nothing to report while hunting
            if (phase_reg != PH_HUNT)
            begin
                step.valid     = 1'b1;
                step.item.kind = slxfr_pkg::KIND_TIMEOUT;
                step.item.last = 1'b1;
            end
            phase_next = PH_HUNT;
        end
        else
        begin
            case (phase_reg)
                PH_TYPE:
                begin
                    held_type_next   = b;
                    running_xor_next = b;
                    phase_next       = PH_LEN;
                end
                PH_LEN:
                begin
                    held_length_next    = b;
                    running_xor_next    = running_xor_reg ^ b;
                    bytes_seen_next     = '0;
                    step.item.frame_len = b;
                    if (b > max_payload_reg)
                    begin
                        step.valid     = 1'b1;
                        step.item.kind = slxfr_pkg::KIND_TOOLONG;
                        step.item.last = 1'b1;
                        phase_next     = PH_HUNT;
                    end
                    else if (b == '0)
                        phase_next = PH_CHECK;
                    else
                        phase_next = PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    step.valid           = 1'b1;
                    step.item.data       = b;
                    step.item.byte_index = bytes_seen_reg;
                    running_xor_next     = running_xor_reg ^ b;
                    bytes_seen_next      = seen_inc;
                    if (seen_inc >= held_length_reg)
                        phase_next = PH_CHECK;
                end
                PH_CHECK:
                begin
                    step.valid     = 1'b1;
                    step.item.kind = (running_xor_reg == b) ? slxfr_pkg::KIND_OK
                                                            : slxfr_pkg::KIND_BADSUM;
                    step.item.data = b;
                    step.item.last = 1'b1;
                    phase_next     = PH_HUNT;
                end
                default:
                begin
                    // hunt: open a fresh frame on the start marker, drop anything else
                    if (b == start_marker_reg)
                    begin
                        held_type_next   = '0;
                        held_length_next = '0;
                        bytes_seen_next  = '0;
                        running_xor_next = '0;
                        phase_next       = PH_TYPE;
                    end
                    else
                        phase_next = PH_HUNT;
                end
            endcase
        end

        if (!accept)
            step.valid = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            start_marker_reg <= slxfr_pkg::START_MARKER_RST;
            max_payload_reg  <= slxfr_pkg::MAX_PAYLOAD_RST;
            held_type_reg    <= '0;
            held_length_reg  <= '0;
            bytes_seen_reg   <= '0;
            running_xor_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    slxfr_pkg::CFG_START_MARKER: start_marker_reg <= cfg_data;
                    slxfr_pkg::CFG_MAX_PAYLOAD:  max_payload_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (accept)
            begin
                phase_reg       <= phase_next;
                held_type_reg   <= held_type_next;
                held_length_reg <= held_length_next;
                bytes_seen_reg  <= bytes_seen_next;
                running_xor_reg <= running_xor_next;
            end
        end
    end

    // A timeout always drops the tracker back to hunting
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.mode == slxfr_pkg::MODE_TIMEOUT) |=> (phase_reg == PH_HUNT))
        else $error("timeout did not return to hunt");

    // The payload counter stays below the announced length
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (bytes_seen_reg < held_length_reg))
        else $error("payload counter ran past frame length");

    // Every frame end is followed by hunting
    assert property (@(posedge clk) disable iff (!rst_n)
        (step.valid && step.item.last) |=> (phase_reg == PH_HUNT))
        else $error("frame end without return to hunt");

endmodule
`default_nettype wire

@@ src/slxfr_outbuf.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slxfr_outbuf: result register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module slxfr_outbuf (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire slxfr_pkg::step_t     step,
    output logic                      hold,
    output logic                      dst_valid,
    input  wire logic                 dst_stall,
    output slxfr_pkg::res_item_t      dst_item
);

    logic                 valid_reg, valid_next;
    slxfr_pkg::res_item_t item_reg;
    logic                 load;

    // register is free when empty or drained this cycle
    assign load       = !valid_reg || !dst_stall;
    assign hold       = !load;
    assign valid_next = load ? step.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && step.valid)
            item_reg <= step.item;
    end

    assign dst_valid = valid_reg;
    assign dst_item  = item_reg;

endmodule
`default_nettype wire

@@ src/start_length_xor_frame_receiver.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A result item is registered: it appears on dst in the cycle after the item that causes it is taken.
// Takes one item per cycle while src_stall is low.
// src_stall rises only while a result waits in the output register and dst stalls.
// Reset (rst_n low, asynchronous): hunt for the start marker, clear frame state,
// start_marker back to 0xAA and max_payload back to 255, output register empty.
// ----------------------------------------------------------------------------
// start_length_xor_frame_receiver: start marker / length / XOR frame receiver
// Hunts for the start marker, reads type, length, payload and checksum, passes
// payload bytes on and ends each frame with a status item.
// ----------------------------------------------------------------------------
module start_length_xor_frame_receiver (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input items: received byte or receive timeout
    input  wire logic                            src_valid,
    output logic                                 src_stall,
    input  wire slxfr_pkg::in_item_t             src_item,
    // result items: payload bytes and frame status
    output logic                                 dst_valid,
    input  wire logic                            dst_stall,
    output slxfr_pkg::res_item_t                 dst_item,
    // configuration writes
    input  wire logic                            cfg_we,
    input  wire logic [slxfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [slxfr_pkg::BYTE_W-1:0]    cfg_data
);

    slxfr_pkg::step_t step;
    logic             hold;
    logic             accept;

    // Take a new item whenever the result register can absorb its result
    assign src_stall = hold;
    assign accept    = src_valid && !hold;

    // Frame tracker: state, registers and per-item decode
    slxfr_fsm u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (src_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step)
    );

    // Result register: hold a result until dst takes it
    slxfr_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .hold      (hold),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_item  (dst_item)
    );

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the start marker / length / XOR frame receiver
// Feeds received bytes and receive timeouts through a valid/stall driver,
// predicts every payload and status item in step with each accepted input
// item, and compares the results field by field as they leave the block.
// Both sides idle at random; the register settings change between phases.
// ----------------------------------------------------------------------------
module tb;
    import slxfr_pkg::*;

    localparam int HALF_PERIOD_NS = 6;
    localparam int LIMIT_CYCLES   = 400000;
    localparam int MAX_REPORTS    = 30;

    // Frame tracker phases of the predictor
    typedef enum logic [2:0] {
        RX_HUNT,
        RX_TYPE,
        RX_LEN,
        RX_PAYLOAD,
        RX_CHECK
    } rx_phase_t;

    // Every input of the block holds a known value from time zero
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 src_valid = 1'b0;
    logic                 src_stall;
    in_item_t             src_item  = '0;
    logic                 dst_valid;
    logic                 dst_stall = 1'b0;
    res_item_t            dst_item;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_START_MARKER;
    logic [BYTE_W-1:0]    cfg_data  = '0;

    // Register copies, updated on each write
    logic [7:0] marker_reg  = START_MARKER_RST;
    logic [7:0] max_len_reg = MAX_PAYLOAD_RST;

    // Predictor state: the frame being tracked
    rx_phase_t  rx_phase      = RX_HUNT;
    logic [7:0] cur_type      = '0;
    logic [7:0] cur_len       = '0;
    logic [7:0] payload_count = '0;
    logic [7:0] sum_xor       = '0;

    in_item_t  pending_items[$];    // input items not yet offered
    res_item_t awaited_results[$];  // predicted results, oldest first

    int mismatch_count = 0;
    int results_seen   = 0;

    // Idle bookkeeping of the driver and the monitor
    int  send_gap       = 0;
    int  hold_left      = 0;
    int  free_left      = 0;
    bit  long_hold_done = 1'b0;

    start_length_xor_frame_receiver DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_item  (dst_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD_NS clk = ~clk;

    // Hard stop in case the block hangs or loses results
    initial
    begin
        #(LIMIT_CYCLES * 2 * HALF_PERIOD_NS);
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction and checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t ns: result error: %s", $time, what);
    endtask

    // Advance the tracked frame by one input item; queue the result it causes.
    task automatic deframe_step(input in_item_t it);
        res_item_t r;
        bit        produced;
        r        = '0;
        produced = 1'b0;
        if (it.mode == MODE_TIMEOUT)
        begin
            // a timeout only matters inside a frame
            if (rx_phase != RX_HUNT)
            begin
                produced   = 1'b1;
                r.kind     = KIND_TIMEOUT;
                r.last     = 1'b1;
                rx_phase   = RX_HUNT;
            end
        end
        else
        begin
            case (rx_phase)
                RX_TYPE:
                begin
                    cur_type = it.rx_byte;
                    sum_xor  = it.rx_byte;
                    rx_phase = RX_LEN;
                end
                RX_LEN:
                begin
                    cur_len       = it.rx_byte;
                    sum_xor       = sum_xor ^ it.rx_byte;
                    payload_count = '0;
                    if (it.rx_byte > max_len_reg)
                    begin
                        // reject at once, no payload is read
                        produced = 1'b1;
                        r.kind   = KIND_TOOLONG;
                        r.last   = 1'b1;
                        rx_phase = RX_HUNT;
                    end
                    else if (it.rx_byte == 8'd0)
                        rx_phase = RX_CHECK;
                    else
                        rx_phase = RX_PAYLOAD;
                end
                RX_PAYLOAD:
                begin
                    produced      = 1'b1;
                    r.kind        = KIND_BYTE;
                    r.data        = it.rx_byte;
                    r.byte_index  = payload_count;
                    sum_xor       = sum_xor ^ it.rx_byte;
                    payload_count = payload_count + 8'd1;
                    if (payload_count >= cur_len)
                        rx_phase = RX_CHECK;
                end
                RX_CHECK:
                begin
                    produced = 1'b1;
                    r.kind   = (sum_xor == it.rx_byte) ? KIND_OK : KIND_BADSUM;
                    r.data   = it.rx_byte;
                    r.last   = 1'b1;
                    rx_phase = RX_HUNT;
                end
                default:
                begin
                    // hunt: only the start marker opens a frame
                    if (it.rx_byte == marker_reg)
                    begin
                        cur_type      = '0;
                        cur_len       = '0;
                        payload_count = '0;
                        sum_xor       = '0;
                        rx_phase      = RX_TYPE;
                    end
                end
            endcase
        end
        if (produced)
        begin
            r.frame_type = cur_type;
            r.frame_len  = cur_len;
            awaited_results.push_back(r);
        end
    endtask

    task automatic check_result(input res_item_t got);
        res_item_t exp;
        if (awaited_results.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result %p", got));
            return;
        end
        exp = awaited_results.pop_front();
        if (got.kind !== exp.kind)
            report_mismatch($sformatf("kind %0d, want %0d", got.kind, exp.kind));
        if (got.frame_type !== exp.frame_type)
            report_mismatch($sformatf("frame_type %h, want %h", got.frame_type, exp.frame_type));
        if (got.frame_len !== exp.frame_len)
            report_mismatch($sformatf("frame_len %h, want %h", got.frame_len, exp.frame_len));
        if (got.data !== exp.data)
            report_mismatch($sformatf("data %h, want %h", got.data, exp.data));
        if (got.byte_index !== exp.byte_index)
            report_mismatch($sformatf("byte_index %0d, want %0d", got.byte_index, exp.byte_index));
        if (got.last !== exp.last)
            report_mismatch($sformatf("last %b, want %b", got.last, exp.last));
    endtask

    // Mostly no idling, often a short gap, now and then a long one.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 25);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer queued items, hold a stalled item, idle between items
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic     nxt_valid;
        in_item_t nxt_item;
        if (rst_n)
        begin
            // predict on the edge that accepts the item
            if (src_valid && !src_stall)
                deframe_step(src_item);
            nxt_valid = src_valid;
            nxt_item  = src_item;
            if (!(src_valid && src_stall))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    nxt_valid = 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    nxt_item  = pending_items.pop_front();
                    nxt_valid = 1'b1;
                    send_gap  = pick_idle();
                end
                else
                    nxt_valid = 1'b0;
            end
            src_valid <= nxt_valid;
            src_item  <= nxt_item;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check accepted results, stall at random
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic nxt_stall;
        if (rst_n)
        begin
            if (dst_valid && !dst_stall)
            begin
                check_result(dst_item);
                results_seen++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                nxt_stall = 1'b1;
            end
            else if (!long_hold_done && results_seen >= 120)
            begin
                // hold off long enough for the block to back up its input
                long_hold_done = 1'b1;
                hold_left      = 80;
                nxt_stall      = 1'b1;
            end
            else if (free_left > 0)
            begin
                free_left--;
                nxt_stall = 1'b0;
            end
            else
            begin
                hold_left = pick_idle();
                free_left = $urandom_range(0, 12);
                nxt_stall = 1'b0;
            end
            dst_stall <= nxt_stall;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_byte(input logic [7:0] b);
        pending_items.push_back(in_item_t'{mode: MODE_BYTE, rx_byte: b});
    endtask

    task automatic queue_timeout();
        // the byte field carries noise; the block must ignore it
        pending_items.push_back(in_item_t'{mode: MODE_TIMEOUT, rx_byte: 8'($urandom)});
    endtask

    // Queue one frame under the current settings. A corrupt frame gets a
    // wrong checksum; a truncated one stops at a random point and times out.
    task automatic queue_frame(input int len, input bit corrupt, input bit truncate);
        logic [7:0] body[$];
        logic [7:0] b;
        logic [7:0] sum;
        int         cut_at;
        body.push_back(marker_reg);
        b   = 8'($urandom);
        sum = b;
        body.push_back(b);
        body.push_back(8'(len));
        sum = sum ^ 8'(len);
        if (len <= max_len_reg)
        begin
            for (int i = 0; i < len; i++)
            begin
                b   = 8'($urandom);
                sum = sum ^ b;
                body.push_back(b);
            end
            body.push_back(corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum);
        end
        cut_at = truncate ? $urandom_range(0, body.size() - 2) : body.size() - 1;
        for (int j = 0; j <= cut_at; j++)
            queue_byte(body[j]);
        if (truncate)
            queue_timeout();
    endtask

    // Mostly complete frames, some with a bad checksum; the rest truncated frames, noise and timeouts.
    task automatic queue_random_traffic(input int budget);
        int made;
        int r;
        int len;
        int size_was;
        made = 0;
        while (made < budget)
        begin
            r = $urandom_range(0, 99);
            if (max_len_reg >= 16)
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 24)
                                                   : $urandom_range(0, 8);
            else if ($urandom_range(0, 99) < 85)
                len = $urandom_range(0, max_len_reg + 2);
            else
                len = $urandom_range(0, 255);
            size_was = pending_items.size();
            if (r < 65)
                queue_frame(len, $urandom_range(0, 3) == 0, 1'b0);
            else if (r < 80)
                queue_frame(len, 1'b0, 1'b1);
            else if (r < 92)
            begin
                // line noise, sometimes a stray marker that opens a bogus frame
                repeat ($urandom_range(1, 4))
                    queue_byte(($urandom_range(0, 9) < 3) ? marker_reg : 8'($urandom));
            end
            else
                queue_timeout();
            made += pending_items.size() - size_was;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_START_MARKER)
            marker_reg = val;
        else
            max_len_reg = val;
    endtask

    // Wait until every item is taken and every result is in, then let the
    // tracker settle before the registers may change. Sample between edges
    // so the driver's updates of the same edge are already visible.
    task automatic drain();
        @(negedge clk);
        while (pending_items.size() > 0 || src_valid || awaited_results.size() > 0)
            @(negedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic run_random_phase(input logic [7:0] marker, input logic [7:0] max_len,
                                    input bit with_full_frame, input int budget);
        write_reg(CFG_START_MARKER, marker);
        write_reg(CFG_MAX_PAYLOAD, max_len);
        // one frame of the largest size reaches the top payload index
        if (with_full_frame)
            queue_frame(255, $urandom_range(0, 1), 1'b0);
        queue_random_traffic(budget);
        drain();
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items under the reset settings
        queue_timeout();                  // timeout while hunting: no result
        queue_byte(8'h00);                // non-marker bytes are dropped
        queue_byte(8'hAA);                // zero length, checksum right after
        queue_byte(8'h00);
        queue_byte(8'h00);
        queue_byte(8'h00);
        queue_byte(8'hAA);                // one payload byte, bad checksum
        queue_byte(8'hFF);
        queue_byte(8'h01);
        queue_byte(8'hFF);
        queue_byte(8'h00);
        queue_byte(8'hAA);                // timeout after the type byte
        queue_byte(8'h5A);
        queue_timeout();
        queue_byte(8'hAA);                // timeout in the middle of the payload
        queue_byte(8'h12);
        queue_byte(8'h03);
        queue_byte(8'h55);
        queue_timeout();
        drain();

        // No payload allowed: any length above zero is too long
        write_reg(CFG_MAX_PAYLOAD, 8'h00);
        queue_byte(8'hAA);
        queue_byte(8'h01);
        queue_byte(8'h01);
        queue_byte(8'hAA);
        queue_byte(8'h01);
        queue_byte(8'h00);
        queue_byte(8'h01);
        drain();

        // Random traffic across several register settings
        run_random_phase(8'h00, 8'hFF, 1'b1, 40);
        run_random_phase(8'hFF, 8'h04, 1'b0, 40);
        run_random_phase(8'($urandom), 8'($urandom_range(1, 12)), 1'b0, 40);
        run_random_phase(START_MARKER_RST, MAX_PAYLOAD_RST, 1'b0, 40);

        if (awaited_results.size() > 0)
            report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
